// ===== rtl/core/psp_pkg.sv =====
// psp_pkg: shared types, constants and codes for the particle store block
// no dependencies; imported by every module of the block
`default_nettype none
package psp_pkg;

   // store geometry: one row of 32 words per slot, 21 of them used
   localparam int SLOTS     = 64;
   localparam int SLOT_W    = 6;
   localparam int ATTR_W    = 5;
   localparam int NUM_ATTR  = 21;
   localparam int ADDR_W    = SLOT_W + ATTR_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;

   // op codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // csr indexes
   localparam logic CSR_GROUND  = 1'b0;
   localparam logic CSR_ATTRACT = 1'b1;

   // attribute indexes
   localparam int A_AGE    = 0;
   localparam int A_LIFE   = 1;
   localparam int A_POSX   = 2;
   localparam int A_POSY   = 3;
   localparam int A_POSZ   = 4;
   localparam int A_VELX   = 5;
   localparam int A_VELY   = 6;
   localparam int A_VELZ   = 7;
   localparam int A_COLR   = 8;
   localparam int A_COLG   = 9;
   localparam int A_COLB   = 10;
   localparam int A_ALPHA  = 11;
   localparam int A_SIZE   = 12;
   localparam int A_GRAV   = 13;
   localparam int A_COLRD  = 14;
   localparam int A_COLGD  = 15;
   localparam int A_COLBD  = 16;
   localparam int A_ALPHAD = 17;
   localparam int A_SIZED  = 18;
   localparam int A_GRAVD  = 19;
   localparam int A_PREVY  = 20;

   // q16.16 constants
   localparam logic signed [31:0] FIX_NEG_ONE = -32'sd65536;
   localparam logic signed [31:0] GROUND_Y    = -32'sd1638400;
   localparam logic signed [31:0] SLOW_VY     = -32'sd327680;
   localparam logic signed [32:0] GRAV_K      = -33'sd642253;
   localparam logic [4:0]         PULL_K      = 5'd25;

   typedef struct packed {
      logic [1:0]          op;
      logic [5:0]          slot;
      logic [4:0]          attribute;
      logic signed [31:0]  value;
      logic [30:0]         time_delta;
      logic signed [31:0]  attract_x;
      logic signed [31:0]  attract_y;
      logic signed [31:0]  attract_z;
   } psp_req_type;

   typedef struct packed {
      logic signed [31:0]  read_data;
      logic [6:0]          live_count;
   } psp_rsp_type;

   // start strobes for the root / divide unit
   typedef struct packed {
      logic sqrt_go;
      logic div_go;
   } rd_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/core/psp_attr_mem.sv =====
// psp_attr_mem: attribute store, one write port, one registered read port
// depends on psp_pkg for the address width and depth
`default_nettype none
module psp_attr_mem
   import psp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [31:0]       wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic [31:0]            rdata
);

   logic [31:0] mem_ff [0:MEM_DEPTH-1];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/core/psp_root_div.sv =====
// psp_root_div: shared iterative unit, integer square root (one bit per cycle)
// and the unit-vector divide (one quotient bit per cycle); depends on psp_pkg
`default_nettype none
module psp_root_div
   import psp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire rd_ctl_type  ctl,
   input  wire logic [61:0] sq_arg,
   input  wire logic [29:0] div_mag,
   input  wire logic [30:0] div_len,
   output logic             done,
   output logic [30:0]      result
);

   localparam logic [4:0] SQRT_STEPS = 5'd31;
   localparam logic [4:0] DIV_STEPS  = 5'd17;

   logic        busy_ff, is_sqrt_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [61:0] rad_ff;
   logic [33:0] rem_ff;
   logic [30:0] acc_ff;
   logic [16:0] numlo_ff;
   logic [30:0] den_ff;

   logic [33:0] sq_rem2, sq_trial, dv_rem2, dv_den;

   always_comb begin
      sq_rem2  = {rem_ff[31:0], rad_ff[61:60]};
      sq_trial = {1'b0, acc_ff, 2'b01};
      dv_rem2  = {rem_ff[32:0], numlo_ff[16]};
      dv_den   = {3'b000, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 5'd1);
         if (ctl.sqrt_go) begin
            busy_ff    <= 1'b1;
            is_sqrt_ff <= 1'b1;
            cnt_ff     <= SQRT_STEPS;
            rad_ff     <= sq_arg;
            rem_ff     <= '0;
            acc_ff     <= '0;
         end else if (ctl.div_go) begin
            busy_ff    <= 1'b1;
            is_sqrt_ff <= 1'b0;
            cnt_ff     <= DIV_STEPS;
            rem_ff     <= {5'd0, div_mag[29:1]};
            numlo_ff   <= {div_mag[0], 16'd0};
            den_ff     <= div_len;
            acc_ff     <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
            end
            if (is_sqrt_ff) begin
               rad_ff <= {rad_ff[59:0], 2'b00};
               if (sq_rem2 >= sq_trial) begin
                  rem_ff <= sq_rem2 - sq_trial;
                  acc_ff <= {acc_ff[29:0], 1'b1};
               end else begin
                  rem_ff <= sq_rem2;
                  acc_ff <= {acc_ff[29:0], 1'b0};
               end
            end else begin
               numlo_ff <= {numlo_ff[15:0], 1'b0};
               if (dv_rem2 >= dv_den) begin
                  rem_ff <= dv_rem2 - dv_den;
                  acc_ff <= {acc_ff[29:0], 1'b1};
               end else begin
                  rem_ff <= dv_rem2;
                  acc_ff <= {acc_ff[29:0], 1'b0};
               end
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !(ctl.sqrt_go || ctl.div_go))
      else $error("root/div restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("done without a running operation");

   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !is_sqrt_ff) |-> (acc_ff <= 31'd65536))
      else $error("unit component above one");

endmodule
`default_nettype wire

// ===== rtl/core/particle_store_physics_step.sv =====
// particle_store_physics_step: top level, request sequencer and tick datapath
// depends on psp_pkg, psp_attr_mem and psp_root_div
//
//   port group | dir | handshake            | word
//   req_       | in  | req_valid/req_ready  | psp_req_type (op, slot, attribute, ...)
//   rsp_       | out | rsp_valid/rsp_ready  | psp_rsp_type (read_data, live_count)
//   csr_       | in  | csr_we               | csr_index selects, csr_wdata bit
//
// after reset a clearing pass over all 2048 words sets every age to -1.0;
// no word is taken during it
// write: stored on acceptance, then ST_DONE loads the result; read: ST_READ takes
// the registered memory word, then ST_DONE; tick: per slot the row is loaded from
// the attribute memory (ST_LOAD) and checked (ST_CHECK); a free slot ends there,
// a live one adds the shared-multiplier steps, plus a 31-step root and three
// 17-step divides when attraction is on, and write-back; an expiring slot goes
// straight to write-back; the single memory port sets the floor
// one word is in flight at a time; a stalled result holds the sequencer
`default_nettype none
module particle_store_physics_step
   import psp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire psp_req_type  req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output psp_rsp_type       rsp_word,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic         csr_wdata
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_DONE, ST_LOAD, ST_CHECK, ST_MUL, ST_ACC,
      ST_GROUND, ST_VEC, ST_SQRT, ST_DIV, ST_WB
   } state_type;

   // one multiply-accumulate step of the tick
   typedef enum logic [3:0] {
      U_PX, U_PY, U_PZ, U_GK, U_VY, U_SQ0, U_SQ1, U_SQ2, U_PULL,
      U_CR, U_CG, U_CB, U_AL, U_SZ, U_GR
   } uop_type;

   localparam logic signed [50:0] SAT_MAX = 51'sd2147483647;
   localparam logic signed [50:0] SAT_MIN = -51'sd2147483648;

   // saturating add of a q16.16 increment
   function automatic logic signed [31:0] sat_acc(input logic signed [31:0] base,
                                                  input logic signed [49:0] inc);
      logic signed [50:0] s;
      s = {{19{base[31]}}, base} + {inc[49], inc};
      if (s > SAT_MAX)      sat_acc = SAT_MAX[31:0];
      else if (s < SAT_MIN) sat_acc = SAT_MIN[31:0];
      else                  sat_acc = s[31:0];
   endfunction

   state_type           state_ff;
   uop_type             uop_ff;
   logic [11:0]         clr_cnt_ff;
   logic [6:0]          slot_ff;
   logic [4:0]          cnt_ff;
   logic signed [31:0]  w_ff [0:NUM_ATTR-1];    // working copy of one slot
   logic [30:0]         dt_ff;
   logic signed [31:0]  tgt_ff [0:2];
   logic                gnd_on_ff, pull_on_ff;
   logic [6:0]          alive_ff, live_n_ff;
   logic signed [65:0]  prod_ff;
   logic signed [31:0]  g_ff;
   logic [61:0]         sum_ff;
   logic [29:0]         mag_ff [0:2];
   logic [2:0]          neg_ff;
   logic [30:0]         len_ff;
   logic signed [31:0]  u25_ff;
   logic [1:0]          axis_ff;
   logic                rd_bad_ff;
   logic [31:0]         pend_ff;
   logic                rsp_valid_ff;
   psp_rsp_type         rsp_word_ff;

   // memory port
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [31:0]         mem_wdata, mem_rdata;

   // root / divide unit
   rd_ctl_type          rd_ctl;
   logic                rd_done;
   logic [30:0]         rd_result, div_len;
   logic [1:0]          div_axis;

   // datapath
   logic signed [32:0]  mul_a, mul_b, dt33;
   logic [4:0]          acc_dst;
   logic signed [49:0]  inc;
   logic signed [31:0]  acc_res;
   logic signed [32:0]  age_sum, neg_vy;
   logic signed [33:0]  dvec [0:2];
   logic [32:0]         dmag [0:2];
   logic [32:0]         dor;
   logic [1:0]          dsh;
   logic [21:0]         q25;
   logic [61:0]         sq_total;
   logic                accept, next_done;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign dt33      = {2'b00, dt_ff};

   // memory address and data selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {slot_ff[SLOT_W-1:0], cnt_ff};
      mem_wdata = w_ff[cnt_ff];
      mem_raddr = {slot_ff[SLOT_W-1:0], cnt_ff};
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff[ADDR_W-1:0];
            // age column resets to -1.0, all others to zero
            mem_wdata = (clr_cnt_ff[ATTR_W-1:0] == ATTR_W'(A_AGE)) ? FIX_NEG_ONE : 32'd0;
         end
         ST_IDLE: begin
            mem_we    = accept && (req_word.op == OP_WRITE)
                        && (req_word.attribute < ATTR_W'(NUM_ATTR));
            mem_waddr = {req_word.slot, req_word.attribute};
            mem_wdata = req_word.value;
            mem_raddr = {req_word.slot, req_word.attribute};
         end
         ST_WB:   mem_we = 1'b1;
         default: ;
      endcase
   end

   // multiplier operands and accumulate target for each step
   always_comb begin
      mul_a   = {{1{w_ff[A_VELX][31]}}, w_ff[A_VELX]};
      mul_b   = dt33;
      acc_dst = 5'(A_POSX);
      unique case (uop_ff)
         U_PX: begin mul_a = 33'(w_ff[A_VELX]); acc_dst = 5'(A_POSX); end
         U_PY: begin mul_a = 33'(w_ff[A_VELY]); acc_dst = 5'(A_POSY); end
         U_PZ: begin mul_a = 33'(w_ff[A_VELZ]); acc_dst = 5'(A_POSZ); end
         U_GK: begin mul_a = GRAV_K; mul_b = 33'(w_ff[A_GRAV]); acc_dst = 5'(A_GRAV); end
         U_VY: begin mul_a = 33'(g_ff); acc_dst = 5'(A_VELY); end
         U_SQ0: begin mul_a = {3'b000, mag_ff[0]}; mul_b = {3'b000, mag_ff[0]}; end
         U_SQ1: begin mul_a = {3'b000, mag_ff[1]}; mul_b = {3'b000, mag_ff[1]}; end
         U_SQ2: begin mul_a = {3'b000, mag_ff[2]}; mul_b = {3'b000, mag_ff[2]}; end
         U_PULL: begin
            mul_a   = 33'(u25_ff);
            acc_dst = 5'(A_VELX) + {3'b000, axis_ff};
         end
         U_CR: begin mul_a = 33'(w_ff[A_COLRD]);  acc_dst = 5'(A_COLR);  end
         U_CG: begin mul_a = 33'(w_ff[A_COLGD]);  acc_dst = 5'(A_COLG);  end
         U_CB: begin mul_a = 33'(w_ff[A_COLBD]);  acc_dst = 5'(A_COLB);  end
         U_AL: begin mul_a = 33'(w_ff[A_ALPHAD]); acc_dst = 5'(A_ALPHA); end
         U_SZ: begin mul_a = 33'(w_ff[A_SIZED]);  acc_dst = 5'(A_SIZE);  end
         U_GR: begin mul_a = 33'(w_ff[A_GRAVD]);  acc_dst = 5'(A_GRAV);  end
         default: ;
      endcase
   end

   // floor shift of the product, then saturating accumulate
   assign inc     = prod_ff[65:16];
   assign acc_res = sat_acc(w_ff[acc_dst], inc);

   assign age_sum = {w_ff[A_AGE][31], w_ff[A_AGE]} + dt33;
   assign neg_vy  = -{w_ff[A_VELY][31], w_ff[A_VELY]};

   // sum of squares including the product now in the pipe
   assign sq_total = sum_ff + prod_ff[61:0];

   // attraction vector: exact difference, magnitude, common halving
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dvec[i] = {{2{tgt_ff[i][31]}}, tgt_ff[i]}
                 - {{2{w_ff[A_POSX + i][31]}}, w_ff[A_POSX + i]};
         dmag[i] = dvec[i][33] ? 33'(-dvec[i]) : dvec[i][32:0];
      end
      dor = dmag[0] | dmag[1] | dmag[2];
      priority if (dor[32]) dsh = 2'd3;
      else if (dor[31])     dsh = 2'd2;
      else if (dor[30])     dsh = 2'd1;
      else                  dsh = 2'd0;
   end

   assign q25 = 22'(rd_result[16:0]) * 22'(PULL_K);

   // root / divide strobes
   assign div_axis       = (state_ff == ST_SQRT) ? 2'd0 : axis_ff + 2'd1;
   assign div_len        = (state_ff == ST_SQRT) ? rd_result : len_ff;
   assign rd_ctl.sqrt_go = (state_ff == ST_ACC) && (uop_ff == U_SQ2);
   assign rd_ctl.div_go  = ((state_ff == ST_SQRT) && rd_done && (rd_result != '0))
                        || ((state_ff == ST_ACC) && (uop_ff == U_PULL) && (axis_ff != 2'd2));

   // end of the slot walk
   assign next_done = (slot_ff == 7'(SLOTS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         gnd_on_ff    <= 1'b0;
         pull_on_ff   <= 1'b0;
         alive_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_GROUND:  gnd_on_ff  <= csr_wdata;
               CSR_ATTRACT: pull_on_ff <= csr_wdata;
            endcase
         end
         // ST_DONE reloads the result register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 12'd1;
               if (clr_cnt_ff == 12'(MEM_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end

            ST_IDLE: begin
               if (accept) begin
                  pend_ff <= '0;
                  unique case (req_word.op)
                     OP_TICK: begin
                        dt_ff     <= req_word.time_delta;
                        tgt_ff[0] <= req_word.attract_x;
                        tgt_ff[1] <= req_word.attract_y;
                        tgt_ff[2] <= req_word.attract_z;
                        slot_ff   <= '0;
                        cnt_ff    <= '0;
                        live_n_ff <= '0;
                        state_ff  <= ST_LOAD;
                     end
                     OP_READ: begin
                        rd_bad_ff <= (req_word.attribute >= ATTR_W'(NUM_ATTR));
                        state_ff  <= ST_READ;
                     end
                     default: state_ff <= ST_DONE;  // write, or no operation
                  endcase
               end
            end

            ST_READ: begin
               pend_ff  <= rd_bad_ff ? 32'd0 : mem_rdata;
               state_ff <= ST_DONE;
            end

            ST_DONE: begin
               // load the result register once it is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_word_ff.read_data <= pend_ff;
                  rsp_word_ff.live_count <= alive_ff;
                  state_ff              <= ST_IDLE;
               end
            end

            ST_LOAD: begin
               // registered read data arrives the cycle after its address
               if (cnt_ff != 5'd0) begin
                  w_ff[cnt_ff - 5'd1] <= mem_rdata;
               end
               if (cnt_ff == 5'(NUM_ATTR)) begin
                  state_ff <= ST_CHECK;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end

            ST_CHECK: begin
               cnt_ff <= '0;
               if (w_ff[A_AGE][31]) begin
                  // free slot, nothing to write back
                  if (next_done) begin
                     alive_ff <= live_n_ff;
                     state_ff <= ST_DONE;
                  end else begin
                     slot_ff  <= slot_ff + 7'd1;
                     state_ff <= ST_LOAD;
                  end
               end else if (age_sum >= $signed({w_ff[A_LIFE][31], w_ff[A_LIFE]})) begin
                  // lifetime reached: free the slot
                  w_ff[A_AGE] <= FIX_NEG_ONE;
                  state_ff    <= ST_WB;
               end else begin
                  w_ff[A_AGE]   <= sat_acc(w_ff[A_AGE], 50'(dt_ff));
                  w_ff[A_PREVY] <= w_ff[A_POSY];
                  if (live_n_ff != 7'd127) begin
                     live_n_ff <= live_n_ff + 7'd1;
                  end
                  uop_ff   <= U_PX;
                  state_ff <= ST_MUL;
               end
            end

            ST_MUL: begin
               prod_ff  <= mul_a * mul_b;
               state_ff <= ST_ACC;
            end

            ST_ACC: begin
               state_ff <= ST_MUL;
               unique case (uop_ff)
                  U_GK:  g_ff <= sat_acc(32'sd0, inc);
                  U_SQ0, U_SQ1, U_SQ2: sum_ff <= sq_total;
                  default: w_ff[acc_dst] <= acc_res;
               endcase
               unique case (uop_ff)
                  U_PX:  uop_ff <= U_PY;
                  U_PY:  uop_ff <= U_PZ;
                  U_PZ:  state_ff <= ST_GROUND;
                  U_GK:  uop_ff <= U_VY;
                  U_VY: begin
                     if (pull_on_ff) state_ff <= ST_VEC;
                     else            uop_ff   <= U_CR;
                  end
                  U_SQ0: uop_ff <= U_SQ1;
                  U_SQ1: uop_ff <= U_SQ2;
                  U_SQ2: state_ff <= ST_SQRT;
                  U_PULL: begin
                     if (axis_ff == 2'd2) begin
                        uop_ff <= U_CR;
                     end else begin
                        axis_ff  <= axis_ff + 2'd1;
                        state_ff <= ST_DIV;
                     end
                  end
                  U_CR:  uop_ff <= U_CG;
                  U_CG:  uop_ff <= U_CB;
                  U_CB:  uop_ff <= U_AL;
                  U_AL:  uop_ff <= U_SZ;
                  U_SZ:  uop_ff <= U_GR;
                  U_GR: begin
                     cnt_ff   <= '0;
                     state_ff <= ST_WB;
                  end
               endcase
            end

            ST_GROUND: begin
               // ground plane: slow ones settle, fast ones bounce at half speed
               if (gnd_on_ff && (w_ff[A_POSY] < GROUND_Y)) begin
                  if (w_ff[A_VELY] > SLOW_VY) begin
                     w_ff[A_POSY] <= GROUND_Y;
                     w_ff[A_VELY] <= '0;
                  end else begin
                     w_ff[A_POSY] <= w_ff[A_PREVY];
                     w_ff[A_VELY] <= neg_vy[32:1];
                  end
               end
               uop_ff   <= U_GK;
               state_ff <= ST_MUL;
            end

            ST_VEC: begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= 30'(dmag[i] >> dsh);
                  neg_ff[i] <= dvec[i][33];
               end
               sum_ff   <= '0;
               uop_ff   <= U_SQ0;
               state_ff <= ST_MUL;
            end

            ST_SQRT: begin
               if (rd_done) begin
                  len_ff  <= rd_result;
                  axis_ff <= 2'd0;
                  if (rd_result == '0) begin
                     // zero vector: no pull
                     uop_ff   <= U_CR;
                     state_ff <= ST_MUL;
                  end else begin
                     state_ff <= ST_DIV;
                  end
               end
            end

            ST_DIV: begin
               if (rd_done) begin
                  u25_ff   <= neg_ff[axis_ff] ? -32'(q25) : 32'(q25);
                  uop_ff   <= U_PULL;
                  state_ff <= ST_MUL;
               end
            end

            ST_WB: begin
               if (cnt_ff == 5'(NUM_ATTR - 1)) begin
                  cnt_ff <= '0;
                  if (next_done) begin
                     alive_ff <= live_n_ff;
                     state_ff <= ST_DONE;
                  end else begin
                     slot_ff  <= slot_ff + 7'd1;
                     state_ff <= ST_LOAD;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   psp_attr_mem u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   psp_root_div u_rootdiv (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rd_ctl),
      .sq_arg  (sq_total),
      .div_mag (mag_ff[div_axis]),
      .div_len (div_len),
      .done    (rd_done),
      .result  (rd_result)
   );

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("word taken during clearing pass");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.live_count <= 7'(SLOTS)))
      else $error("live count above slot count");

   a_wb_column: assert property (@(posedge clock) disable iff (reset)
      (mem_we && (state_ff != ST_CLEAR)) |-> (mem_waddr[ATTR_W-1:0] < ATTR_W'(NUM_ATTR)))
      else $error("write to an unused column");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second word taken before the first finished");

endmodule
`default_nettype wire
